[rtl/core/dq_pkg.sv]
package dq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_REAR   = 3'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
  } cell_ctrl_t;

endpackage

[rtl/core/dq_cell.sv]
module dq_cell
  import dq_pkg::*;
(
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [IDX_W-1:0]      index_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] push_value_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rear_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [CNT_W-1:0]      index_ext;
  logic                  is_free_head;
  logic                  is_last;

  assign index_ext    = CNT_W'(index_i);
  assign is_free_head = (index_ext == count_i);
  assign is_last      = ((index_ext + CNT_W'(1)) == count_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push_front) begin
      data_d = left_data_i;
    end else if (ctrl_i.pop_front) begin
      data_d = right_data_i;
    end else if (ctrl_i.push_rear && is_free_head) begin
      data_d = push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // only the rear cell drives its word onto the or-tree
  assign rear_o = is_last ? data_q : '0;

endmodule

[rtl/core/double_ended_queue.sv]
// Bounded double-ended queue of DEPTH words held in a row of cells, the front
// word always in cell 0. One operation (push front, push rear, pop front, pop
// rear or status query) is taken in every cycle; busy never rises. The result
// appears one cycle after start, for one cycle, marked by done_o, and the
// receiver must take it then. The whole row shifts by one cell in the cycle
// of a front push or pop, which sets the one-cycle figure. A pop of an empty
// queue reports underflow and a push to a full queue reports overflow; both
// leave the queue unchanged.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            mode_i,
  input  logic [31:0]           push_value_i,
  output logic                  done_o,
  output logic [31:0]           pop_value_o,
  output logic [1:0]            status_o,
  output logic                  is_empty_o,
  output logic [4:0]            occupancy_o
);

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q;
  logic [31:0]           pop_value_q, pop_value_d;
  logic [1:0]            status_q, status_d;
  logic                  accept, full, empty;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rear [DEPTH];
  logic [DATA_WIDTH-1:0] rear_word;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign push_word = push_value_i[DATA_WIDTH-1:0];

  assign ctrl.push_front = accept && (mode_i == MODE_PUSH_FRONT) && !full;
  assign ctrl.push_rear  = accept && (mode_i == MODE_PUSH_REAR)  && !full;
  assign ctrl.pop_front  = accept && (mode_i == MODE_POP_FRONT)  && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word, right_word;
    if (i == 0) begin : g_first
      assign left_word = push_word;
    end else begin : g_mid
      assign left_word = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_inner
      assign right_word = cell_data[i+1];
    end

    dq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .index_i      (IDX_W'(i)),
      .count_i      (count_q),
      .push_value_i (push_word),
      .left_data_i  (left_word),
      .right_data_i (right_word),
      .data_o       (cell_data[i]),
      .rear_o       (cell_rear[i])
    );
  end

  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | cell_rear[i];
    end
  end

  always_comb begin
    count_d     = count_q;
    pop_value_d = '0;
    status_d    = STATUS_OK;
    unique case (mode_i)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (full) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_d = STATUS_UNDERFLOW;
        end else begin
          count_d     = count_q - CNT_W'(1);
          pop_value_d = 32'(cell_data[0]);
        end
      end
      MODE_POP_REAR: begin
        if (empty) begin
          status_d = STATUS_UNDERFLOW;
        end else begin
          count_d     = count_q - CNT_W'(1);
          pop_value_d = 32'(rear_word);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
    end
  end

  assign done_o      = done_q;
  assign pop_value_o = pop_value_q;
  assign status_o    = status_q;
  assign is_empty_o  = (count_q == '0);
  assign occupancy_o = 5'(count_q);

endmodule

[tb/double_ended_queue_tb.sv]
`timescale 1ns / 100ps

module double_ended_queue_tb;
  import dq_pkg::*;

  // mode codes the package leaves unnamed; 5 to 7 behave as a query
  localparam logic [2:0] MODE_QUERY    = 3'd4;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int RANDOM_OPS = 1800;
  localparam int MAX_PRINTS = 60;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] value;
    int          gap;
  } deque_op_t;

  typedef struct packed {
    logic [31:0]      pop_value;
    logic [1:0]       status;
    logic             is_empty;
    logic [CNT_W-1:0] occupancy;
  } deque_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic [2:0]  mode_i       = '0;
  logic [31:0] push_value_i = '0;
  logic        busy;
  logic        done_o;
  logic [31:0] pop_value_o;
  logic [1:0]  status_o;
  logic        is_empty_o;
  logic [4:0]  occupancy_o;

  double_ended_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .push_value_i (push_value_i),
    .done_o       (done_o),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .is_empty_o   (is_empty_o),
    .occupancy_o  (occupancy_o)
  );

  always #4 clk_i = ~clk_i;

  deque_op_t     pending_ops[$];
  deque_result_t due_results[$];
  int            total_ops   = 0;
  int            n_accepted  = 0;
  int            n_mismatch  = 0;

  // shadow of the queue contents
  logic [DATA_WIDTH-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]      front_idx  = '0;
  logic [IDX_W-1:0]      rear_idx   = '0;
  logic [CNT_W-1:0]      word_count = '0;

  function automatic logic [IDX_W-1:0] idx_up(logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_down(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic deque_result_t apply_deque_op(logic [2:0] op, logic [31:0] v);
    deque_result_t r;
    r = '0;
    r.status = STATUS_OK;
    if (op == MODE_PUSH_FRONT || op == MODE_PUSH_REAR) begin
      if (word_count >= CNT_W'(DEPTH)) begin
        r.status = STATUS_OVERFLOW;
      end else if (op == MODE_PUSH_FRONT) begin
        front_idx = idx_down(front_idx);
        ring_words[front_idx] = v[DATA_WIDTH-1:0];
        word_count++;
      end else begin
        ring_words[rear_idx] = v[DATA_WIDTH-1:0];
        rear_idx = idx_up(rear_idx);
        word_count++;
      end
    end else if (op == MODE_POP_FRONT || op == MODE_POP_REAR) begin
      if (word_count == '0) begin
        r.status = STATUS_UNDERFLOW;
      end else if (op == MODE_POP_FRONT) begin
        r.pop_value = 32'(ring_words[front_idx]);
        front_idx = idx_up(front_idx);
        word_count--;
      end else begin
        rear_idx = idx_down(rear_idx);
        r.pop_value = 32'(ring_words[rear_idx]);
        word_count--;
      end
    end
    r.is_empty  = (word_count == '0);
    r.occupancy = word_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTS)
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic add_op(logic [2:0] m, logic [31:0] v, int g);
    deque_op_t o;
    o.mode  = m;
    o.value = v;
    o.gap   = g;
    pending_ops.push_back(o);
    total_ops++;
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: one word offered per accept, with its idle gap first
  deque_op_t staged_op;
  bit        staged_ok = 1'b0;
  int        gap_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start        <= 1'b0;
      mode_i       <= '0;
      push_value_i <= '0;
      staged_ok    = 1'b0;
      gap_left     = 0;
    end else begin
      if (start && !busy) begin
        due_results.push_back(apply_deque_op(mode_i, push_value_i));
        n_accepted++;
      end
      if (!(start && busy)) begin
        if (!staged_ok && pending_ops.size() != 0) begin
          staged_op = pending_ops.pop_front();
          staged_ok = 1'b1;
          gap_left  = staged_op.gap;
        end
        if (staged_ok && gap_left == 0) begin
          start        <= 1'b1;
          mode_i       <= staged_op.mode;
          push_value_i <= staged_op.value;
          staged_ok    = 1'b0;
        end else begin
          // junk on the payload while idle
          start        <= 1'b0;
          mode_i       <= 3'($urandom);
          push_value_i <= $urandom;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // monitor: results cannot be held off, so take every strobe
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word, status", status_o, 0);
      end else begin
        want = due_results.pop_front();
        if (pop_value_o !== want.pop_value)
          report_mismatch("pop_value", pop_value_o, want.pop_value);
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (is_empty_o !== want.is_empty)
          report_mismatch("is_empty", is_empty_o, want.is_empty);
        if (occupancy_o !== want.occupancy)
          report_mismatch("occupancy", occupancy_o, want.occupancy);
      end
    end
  end

  initial begin
    int        burst_left;
    int        push_pct;
    bit        quiet;
    int        r;
    logic [2:0]  m;
    logic [31:0] v;

    // directed: empty corner cases, single element, fill to overflow, a pop from each end
    add_op(MODE_QUERY, 32'h0, 0);
    add_op(MODE_POP_FRONT, 32'hffff_ffff, 0);
    add_op(MODE_POP_REAR, 32'h0, 1);
    add_op(MODE_PUSH_FRONT, 32'h0, 0);
    add_op(MODE_POP_REAR, 32'h0, 0);
    add_op(MODE_PUSH_REAR, 32'hffff_ffff, 2);
    add_op(MODE_POP_FRONT, 32'h0, 0);
    for (int i = 0; i < DEPTH; i++)
      add_op((i % 2) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
             (i % 2) ? ~(32'h1 << i) : (32'h1 << (31 - i)), 0);
    add_op(MODE_PUSH_FRONT, 32'hdead_beef, 0);
    add_op(MODE_PUSH_REAR, 32'hffff_ffff, 3);
    add_op(MODE_SPARE_LO, 32'h1234_5678, 0);
    add_op(MODE_SPARE_HI, 32'h0, 0);
    add_op(MODE_POP_FRONT, 32'h0, 0);
    add_op(MODE_POP_REAR, 32'h0, 0);

    // random: bursts that lean toward filling, draining or neither
    burst_left = 0;
    push_pct   = 50;
    quiet      = 1'b0;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 60);
        r = $urandom_range(0, 2);
        push_pct = (r == 0) ? 85 : (r == 1) ? 50 : 15;
        quiet = ($urandom_range(0, 3) == 0);
      end
      burst_left--;
      if ($urandom_range(0, 99) < 5)
        m = 3'($urandom_range(MODE_QUERY, MODE_SPARE_HI));
      else if ($urandom_range(0, 99) < push_pct)
        m = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
      else
        m = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
      r = $urandom_range(0, 19);
      v = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom;
      add_op(m, v, pick_gap(quiet));
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_accepted == total_ops && due_results.size() == 0);
    repeat (4) @(posedge clk_i);
    if (n_mismatch == 0)
      $display("double_ended_queue: match");
    else
      $display("double_ended_queue: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("double_ended_queue: mismatch");
    $finish;
  end

endmodule
